[rtl/yuyv_pkg.sv]
// ============================================================================
// YUYV to BGR converter package
// Shared types and fixed-point BT.601 coefficients.
// ============================================================================
package yuyv_pkg;

    localparam int COEF_FRAC_BITS = 10;

    // Coefficients are below 4.0, so F+2 magnitude bits plus a sign bit.
    localparam int COEF_W = COEF_FRAC_BITS + 3;
    localparam int OPND_W = 9;
    localparam int PROD_W = COEF_W + OPND_W;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam coef_t K_LUMA = coef_t'(((1164 << COEF_FRAC_BITS) + 500) / 1000);
    localparam coef_t K_UB   = coef_t'(((2018 << COEF_FRAC_BITS) + 500) / 1000);
    localparam coef_t K_UG   = coef_t'(((391 << COEF_FRAC_BITS) + 500) / 1000);
    localparam coef_t K_VG   = coef_t'(((813 << COEF_FRAC_BITS) + 500) / 1000);
    localparam coef_t K_VR   = coef_t'(((1596 << COEF_FRAC_BITS) + 500) / 1000);

    localparam opnd_t LUMA_OFFSET   = opnd_t'(16);
    localparam opnd_t CHROMA_OFFSET = opnd_t'(128);

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end_in;
    } macropixel_t;

    typedef struct packed {
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
        logic       frame_end_out;
    } pixel_pair_t;

    // Products after the multiply stage
    typedef struct packed {
        prod_t lum_first;
        prod_t lum_second;
        prod_t u_blue;
        prod_t u_green;
        prod_t v_green;
        prod_t v_red;
        logic  frame_end;
    } prod_stage_t;

    // Chroma terms merged
    typedef struct packed {
        prod_t lum_first;
        prod_t lum_second;
        prod_t u_blue;
        prod_t uv_green;
        prod_t v_red;
        logic  frame_end;
    } chroma_stage_t;

    // Unclamped channel sums
    typedef struct packed {
        prod_t blue_first;
        prod_t green_first;
        prod_t red_first;
        prod_t blue_second;
        prod_t green_second;
        prod_t red_second;
        logic  frame_end;
    } sum_stage_t;

endpackage

[rtl/yuyv_to_bgra_converter_core.sv]
// ============================================================================
// YUYV 4:2:2 to BGR converter core
// One macropixel in, two BT.601 studio-range BGR pixels out.
//
// Channel     Ports                          Dir  Handshake
// request     start, busy, macropixel        in   start & !busy
// result      result_strobe, pixels          out  one-cycle strobe
//
// Four register stages: multiply, chroma merge, channel sum, clamp.
// One request per clock; each result passes the multiply, chroma merge, channel sum and clamp registers in order.
// busy is always low: the pipeline never stalls, the receiver cannot either.
// Reset clears the stage valid bits only; nothing is pending afterward.
// ============================================================================
module yuyv_to_bgra_converter_core
    import yuyv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  macropixel_t macropixel,
    output logic        result_strobe,
    output pixel_pair_t pixels
);

    logic        accept;
    logic        prod_valid;
    prod_stage_t prod;
    logic        sum_valid;
    sum_stage_t  sums;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    yuyv_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .macropixel (macropixel),
        .valid      (prod_valid),
        .prod       (prod)
    );

    yuyv_sum u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .valid      (sum_valid),
        .sums       (sums)
    );

    yuyv_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sums      (sums),
        .strobe    (result_strobe),
        .pixels    (pixels)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 result_strobe)
        else $error("request did not produce a result after 4 cycles");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(accept, 4))
        else $error("result without a matching request");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> pixels.frame_end_out == $past(macropixel.frame_end_in, 4))
        else $error("frame end flag lost in pipeline");

endmodule

[rtl/yuyv_mult.sv]
// ============================================================================
// YUYV multiply stage
// Removes the luma/chroma offsets and forms the six coefficient products.
// ============================================================================
module yuyv_mult
    import yuyv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  macropixel_t macropixel,
    output logic        valid,
    output prod_stage_t prod
);

    opnd_t       y0_off;
    opnd_t       y1_off;
    opnd_t       cb_off;
    opnd_t       cr_off;
    logic        valid_reg;
    logic        valid_next;
    prod_stage_t prod_reg;
    prod_stage_t prod_next;

    always_comb
    begin
        y0_off = opnd_t'({1'b0, macropixel.luma_first}) - LUMA_OFFSET;
        y1_off = opnd_t'({1'b0, macropixel.luma_second}) - LUMA_OFFSET;
        cb_off = opnd_t'({1'b0, macropixel.chroma_blue}) - CHROMA_OFFSET;
        cr_off = opnd_t'({1'b0, macropixel.chroma_red}) - CHROMA_OFFSET;

        prod_next.lum_first  = prod_t'(K_LUMA) * prod_t'(y0_off);
        prod_next.lum_second = prod_t'(K_LUMA) * prod_t'(y1_off);
        prod_next.u_blue     = prod_t'(K_UB) * prod_t'(cb_off);
        prod_next.u_green    = prod_t'(K_UG) * prod_t'(cb_off);
        prod_next.v_green    = prod_t'(K_VG) * prod_t'(cr_off);
        prod_next.v_red      = prod_t'(K_VR) * prod_t'(cr_off);
        prod_next.frame_end  = macropixel.frame_end_in;
        valid_next           = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_next)
        begin
            prod_reg <= prod_next;
        end
    end

    assign valid = valid_reg;
    assign prod  = prod_reg;

endmodule

[rtl/yuyv_sum.sv]
// ============================================================================
// YUYV sum stages
// Merges the green chroma terms, then adds luma to form each channel.
// ============================================================================
module yuyv_sum
    import yuyv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        prod_valid,
    input  prod_stage_t prod,
    output logic        valid,
    output sum_stage_t  sums
);

    logic          chroma_valid_reg;
    logic          chroma_valid_next;
    chroma_stage_t chroma_reg;
    chroma_stage_t chroma_next;
    logic          sum_valid_reg;
    logic          sum_valid_next;
    sum_stage_t    sum_reg;
    sum_stage_t    sum_next;

    always_comb
    begin
        chroma_next.lum_first  = prod.lum_first;
        chroma_next.lum_second = prod.lum_second;
        chroma_next.u_blue     = prod.u_blue;
        chroma_next.uv_green   = prod.u_green + prod.v_green;
        chroma_next.v_red      = prod.v_red;
        chroma_next.frame_end  = prod.frame_end;
        chroma_valid_next      = prod_valid;

        sum_next.blue_first   = chroma_reg.lum_first + chroma_reg.u_blue;
        sum_next.green_first  = chroma_reg.lum_first - chroma_reg.uv_green;
        sum_next.red_first    = chroma_reg.lum_first + chroma_reg.v_red;
        sum_next.blue_second  = chroma_reg.lum_second + chroma_reg.u_blue;
        sum_next.green_second = chroma_reg.lum_second - chroma_reg.uv_green;
        sum_next.red_second   = chroma_reg.lum_second + chroma_reg.v_red;
        sum_next.frame_end    = chroma_reg.frame_end;
        sum_valid_next        = chroma_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chroma_valid_reg <= 1'b0;
            sum_valid_reg    <= 1'b0;
        end
        else
        begin
            chroma_valid_reg <= chroma_valid_next;
            sum_valid_reg    <= sum_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chroma_valid_next)
        begin
            chroma_reg <= chroma_next;
        end
        if (sum_valid_next)
        begin
            sum_reg <= sum_next;
        end
    end

    assign valid = sum_valid_reg;
    assign sums  = sum_reg;

endmodule

[rtl/yuyv_clamp.sv]
// ============================================================================
// YUYV clamp stage
// Drops the fraction and saturates each channel to 0..255.
// ============================================================================
module yuyv_clamp
    import yuyv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sum_valid,
    input  sum_stage_t  sums,
    output logic        strobe,
    output pixel_pair_t pixels
);

    logic        strobe_reg;
    logic        strobe_next;
    pixel_pair_t pixels_reg;
    pixel_pair_t pixels_next;

    function automatic logic [7:0] sat8(input prod_t acc);
        logic [7:0] res;
        if (acc[PROD_W-1])
        begin
            res = 8'h00;
        end
        else if (|acc[PROD_W-2:COEF_FRAC_BITS+8])
        begin
            res = 8'hFF;
        end
        else
        begin
            res = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
        return res;
    endfunction

    always_comb
    begin
        pixels_next.blue_first    = sat8(sums.blue_first);
        pixels_next.green_first   = sat8(sums.green_first);
        pixels_next.red_first     = sat8(sums.red_first);
        pixels_next.blue_second   = sat8(sums.blue_second);
        pixels_next.green_second  = sat8(sums.green_second);
        pixels_next.red_second    = sat8(sums.red_second);
        pixels_next.frame_end_out = sums.frame_end;
        strobe_next               = sum_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (strobe_next)
        begin
            pixels_reg <= pixels_next;
        end
    end

    assign strobe = strobe_reg;
    assign pixels = pixels_reg;

endmodule

[bench/yuyv_to_bgra_converter_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// YUYV to BGR converter core testbench
// Sends YUYV macropixels through the start/busy request port and checks
// every strobed pixel pair against a BT.601 fixed-point predictor, in order,
// with random request gaps, full-rate bursts and frame-end marking.
// ============================================================================
module yuyv_to_bgra_converter_core_tb
    import yuyv_pkg::*;
();

    localparam int FRAC        = 10;
    localparam int C_LUMA      = ((1164 << FRAC) + 500) / 1000;
    localparam int C_U_BLUE    = ((2018 << FRAC) + 500) / 1000;
    localparam int C_U_GREEN   = ((391 << FRAC) + 500) / 1000;
    localparam int C_V_GREEN   = ((813 << FRAC) + 500) / 1000;
    localparam int C_V_RED     = ((1596 << FRAC) + 500) / 1000;
    localparam int CYCLE_LIMIT = 60000;
    localparam int DRAIN       = 10;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    macropixel_t macropixel;
    logic        result_strobe;
    pixel_pair_t pixels;

    pixel_pair_t pending_pairs[$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          frames_sent    = 0;
    int          pairs_checked  = 0;
    int          cycle_count    = 0;
    bit          full_rate      = 1'b0;

    yuyv_to_bgra_converter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .macropixel    (macropixel),
        .result_strobe (result_strobe),
        .pixels        (pixels)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] clamp_channel(input int acc);
        int shifted;
        if (acc < 0)
            return 8'd0;
        shifted = acc >>> FRAC;
        return (shifted > 255) ? 8'd255 : shifted[7:0];
    endfunction

    function automatic pixel_pair_t predict_pixel_pair(input macropixel_t mp);
        pixel_pair_t pp;
        int cb;
        int cr;
        int lum0;
        int lum1;
        cb   = int'(mp.chroma_blue) - 128;
        cr   = int'(mp.chroma_red) - 128;
        lum0 = C_LUMA * (int'(mp.luma_first) - 16);
        lum1 = C_LUMA * (int'(mp.luma_second) - 16);
        pp.blue_first    = clamp_channel(lum0 + C_U_BLUE * cb);
        pp.green_first   = clamp_channel(lum0 - C_U_GREEN * cb - C_V_GREEN * cr);
        pp.red_first     = clamp_channel(lum0 + C_V_RED * cr);
        pp.blue_second   = clamp_channel(lum1 + C_U_BLUE * cb);
        pp.green_second  = clamp_channel(lum1 - C_U_GREEN * cb - C_V_GREEN * cr);
        pp.red_second    = clamp_channel(lum1 + C_V_RED * cr);
        pp.frame_end_out = mp.frame_end_in;
        return pp;
    endfunction

    // Mostly uniform, with a bias toward the studio-range boundaries and 0 and 255.
    function automatic logic [7:0] draw_sample();
        case ($urandom_range(0, 11))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd240;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic macropixel_t make_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                                    input logic [7:0] y1, input logic [7:0] v,
                                                    input logic fe);
        macropixel_t mp;
        mp.luma_first   = y0;
        mp.chroma_blue  = u;
        mp.luma_second  = y1;
        mp.chroma_red   = v;
        mp.frame_end_in = fe;
        return mp;
    endfunction

    // Called at a rising edge; returns at the edge that accepted the request.
    task automatic send_macropixel(input macropixel_t mp);
        int gap;
        bit taken;
        gap = full_rate ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        macropixel <= mp;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        pending_pairs.push_back(predict_pixel_pair(mp));
        items_sent++;
        if (mp.frame_end_in)
            frames_sent++;
    endtask

    task automatic test_directed_corners();
        send_macropixel(make_macropixel(8'd0,   8'd128, 8'd255, 8'd128, 1'b0));
        send_macropixel(make_macropixel(8'd16,  8'd128, 8'd235, 8'd128, 1'b0));
        send_macropixel(make_macropixel(8'd15,  8'd128, 8'd236, 8'd128, 1'b0));
        send_macropixel(make_macropixel(8'd255, 8'd128, 8'd0,   8'd128, 1'b1));
        send_macropixel(make_macropixel(8'd128, 8'd0,   8'd128, 8'd0,   1'b0));
        send_macropixel(make_macropixel(8'd128, 8'd0,   8'd128, 8'd255, 1'b0));
        send_macropixel(make_macropixel(8'd128, 8'd255, 8'd128, 8'd0,   1'b0));
        send_macropixel(make_macropixel(8'd128, 8'd255, 8'd128, 8'd255, 1'b1));
        send_macropixel(make_macropixel(8'd100, 8'd16,  8'd200, 8'd240, 1'b0));
        send_macropixel(make_macropixel(8'd100, 8'd240, 8'd200, 8'd16,  1'b0));
        // saturation high and negative sums
        send_macropixel(make_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        send_macropixel(make_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
        send_macropixel(make_macropixel(8'd235, 8'd240, 8'd16,  8'd240, 1'b0));
        send_macropixel(make_macropixel(8'd16,  8'd16,  8'd235, 8'd16,  1'b1));
        send_macropixel(make_macropixel(8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0));
        send_macropixel(make_macropixel(8'hAA,  8'h55,  8'hAA,  8'h55,  1'b1));
    endtask

    task automatic test_random_frames(input int item_target);
        int len;
        int stop_at;
        stop_at = items_sent + item_target;
        while (items_sent < stop_at)
        begin
            len       = $urandom_range(1, 48);
            full_rate = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                send_macropixel(make_macropixel(draw_sample(), draw_sample(), draw_sample(),
                                                draw_sample(), i == len - 1));
        end
        full_rate = 1'b0;
    endtask

    task automatic test_full_rate(input int count);
        full_rate = 1'b1;
        for (int i = 0; i < count; i++)
            send_macropixel(make_macropixel(8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            $urandom_range(0, 15) == 0));
        full_rate = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Results are stable between edges; sampling on the falling edge avoids races.
    always @(negedge clk)
    begin
        pixel_pair_t exp_pp;
        if (rst_n === 1'b1 && result_strobe !== 1'b0)
        begin
            if (result_strobe !== 1'b1 || pending_pairs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, strobe %b, pixels %h",
                         $time, result_strobe, pixels);
            end
            else
            begin
                exp_pp = pending_pairs.pop_front();
                pairs_checked++;
                check_field("blue_first",   exp_pp.blue_first,   pixels.blue_first);
                check_field("green_first",  exp_pp.green_first,  pixels.green_first);
                check_field("red_first",    exp_pp.red_first,    pixels.red_first);
                check_field("blue_second",  exp_pp.blue_second,  pixels.blue_second);
                check_field("green_second", exp_pp.green_second, pixels.green_second);
                check_field("red_second",   exp_pp.red_second,   pixels.red_second);
                check_field("frame_end_out", 8'(exp_pp.frame_end_out),
                            8'(pixels.frame_end_out));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_pairs.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        macropixel = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_frames(1030);
        test_full_rate(250);

        start <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d macropixels in %0d frames, checked %0d pixel pairs",
                 items_sent, frames_sent, pairs_checked);
        $display("Covered luma/chroma extremes, clamping both ways, gaps and full rate");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/yuyv_pkg.sv
rtl/yuyv_mult.sv
rtl/yuyv_sum.sv
rtl/yuyv_clamp.sv
rtl/yuyv_to_bgra_converter_core.sv
bench/yuyv_to_bgra_converter_core_tb.sv
